@@ design/ikht_pkg.sv @@
// Package for the integer key hash table: widths, reset constants, command codes,
// and the 64-bit key mix function. It has no dependencies.
package ikht_pkg;

  localparam int KeyW = 64;
  localparam int ValW = 64;
  localparam int CfgW = 11;
  localparam int HashW = 32;
  localparam int DefMaxBuckets = 1024;
  localparam int DefWays = 4;
  localparam logic [CfgW-1:0] BucketCountReset = 11'd1024;

  localparam logic CmdInsert = 1'b0;
  localparam logic CmdLookup = 1'b1;

  // Shift-add-xor mix of the key, cut to its low 32 bits
  function automatic logic [HashW-1:0] mix_key(input logic [KeyW-1:0] k);
    logic [KeyW-1:0] h;
    h = k;
    h = h + ~(h << 15);
    h = h ^ (h >> 10);
    h = h + (h << 3);
    h = h ^ (h >> 6);
    h = h + ~(h << 11);
    h = h ^ (h >> 16);
    return h[HashW-1:0];
  endfunction

endpackage

@@ design/ikht_mod.sv @@
// Iterative restoring modulo: 32-bit hash mod the bucket count, one bit per cycle.
// Uses ikht_pkg for widths.
module ikht_mod #(
  parameter int BW = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           go,
  input  logic [ikht_pkg::HashW-1:0]     dividend,
  input  logic [BW:0]                    divisor,
  output logic                           done,
  output logic [BW-1:0]                  remainder
);

  localparam int CntW = $clog2(ikht_pkg::HashW + 1);

  logic [ikht_pkg::HashW-1:0] shreg;
  logic [BW+1:0]              rem;
  logic [CntW-1:0]            cnt;
  logic                       active;
  logic [BW+1:0]              trial;

  assign trial = {rem[BW:0], shreg[ikht_pkg::HashW-1]};

  // One quotient bit a cycle, MSB first
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        active <= 1'b1;
        cnt    <= CntW'(ikht_pkg::HashW);
      end else if (active) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      shreg <= dividend;
      rem   <= '0;
    end else if (active) begin
      shreg <= shreg << 1;
      if (trial >= {1'b0, divisor}) rem <= trial - {1'b0, divisor};
      else rem <= trial;
    end
  end

  assign remainder = rem[BW-1:0];

endmodule

@@ design/ikht_store.sv @@
// Entry memories and valid bits for the table, one way per cycle.
// Uses ikht_pkg for widths.
module ikht_store #(
  parameter int AW = 12
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [AW-1:0]              rd_addr,
  output logic                       rd_valid,
  output logic [ikht_pkg::KeyW-1:0]  rd_key,
  output logic [ikht_pkg::ValW-1:0]  rd_value,
  input  logic                       wr_en,
  input  logic                       wr_key_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [ikht_pkg::KeyW-1:0]  wr_key,
  input  logic [ikht_pkg::ValW-1:0]  wr_value,
  output logic                       clr_busy
);

  localparam int Depth = 1 << AW;

  logic [ikht_pkg::KeyW-1:0] key_mem [Depth];
  logic [ikht_pkg::ValW-1:0] val_mem [Depth];
  logic                      vld_mem [Depth];
  logic [AW:0]               clr_ptr;

  assign clr_busy = !clr_ptr[AW];

  // Valid memory: clearing sweep after reset, then written on inserts
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr <= '0;
    end else if (clr_busy) begin
      clr_ptr <= clr_ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) vld_mem[clr_ptr[AW-1:0]] <= 1'b0;
    else if (wr_en) vld_mem[wr_addr] <= 1'b1;
    rd_valid <= vld_mem[rd_addr];
  end

  // Key and value memories
  always_ff @(posedge clk) begin
    if (wr_en && wr_key_en) key_mem[wr_addr] <= wr_key;
    if (wr_en) val_mem[wr_addr] <= wr_value;
    rd_key   <= key_mem[rd_addr];
    rd_value <= val_mem[rd_addr];
  end

endmodule

@@ design/integer_key_hash_table.sv @@
// Integer key hash table. One command at a time: busy rises the cycle after
// start, and done marks the single result word. busy is low again in that
// same cycle, so a new command can be taken then. Each command runs the
// bit-serial 32-bit modulo by bucket_count and then one memory read per way
// of the bucket. After reset the valid memory is swept with busy high. The
// result is shown for one cycle on done and cannot be stalled.
// Depends on ikht_pkg, ikht_mod and ikht_store.
module integer_key_hash_table #(
  parameter int MAX_BUCKETS = ikht_pkg::DefMaxBuckets,
  parameter int WAYS        = ikht_pkg::DefWays
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       command,
  input  logic [ikht_pkg::KeyW-1:0]  key,
  input  logic [ikht_pkg::ValW-1:0]  value,
  output logic                       done,
  output logic                       found,
  output logic [ikht_pkg::ValW-1:0]  read_value,
  output logic                       status,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ikht_pkg::CfgW-1:0]  cfg_data
);

  localparam int BW  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int WW  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int AW  = BW + WW;
  localparam int WCW = $clog2(WAYS + 1);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StHash = 3'd1;
  localparam logic [2:0] StMod  = 3'd2;
  localparam logic [2:0] StRead = 3'd3;
  localparam logic [2:0] StCmp  = 3'd4;
  localparam logic [2:0] StDone = 3'd5;

  logic [2:0]                 state;
  logic [ikht_pkg::CfgW-1:0]  bucket_count;
  logic                       cmd_r;
  logic [ikht_pkg::KeyW-1:0]  key_r;
  logic [ikht_pkg::ValW-1:0]  val_r;
  logic [BW-1:0]              bucket;
  logic [WCW-1:0]             way;
  logic                       hit;
  logic [WW-1:0]              hit_way;
  logic                       has_free;
  logic [WW-1:0]              free_way;
  logic [ikht_pkg::ValW-1:0]  hit_value;
  logic [BW:0]                nbuck;
  logic                       mod_go, mod_done;
  logic [BW-1:0]              mod_rem;
  logic                       rd_valid;
  logic [ikht_pkg::KeyW-1:0]  rd_key;
  logic [ikht_pkg::ValW-1:0]  rd_value;
  logic                       clr_busy;
  logic                       wr_en, wr_key_en;
  logic [WW-1:0]              wr_way;
  logic [WW-1:0]              cmp_way;

  // Clamp bucket count to 1..MAX_BUCKETS
  always_comb begin
    priority if (bucket_count == '0) nbuck = (BW+1)'(1);
    else if (32'(bucket_count) > MAX_BUCKETS) nbuck = (BW+1)'(MAX_BUCKETS);
    else nbuck = (BW+1)'(bucket_count);
  end

  assign cfg_ready = (state == StIdle);
  assign busy      = (state != StIdle) || clr_busy;
  assign mod_go    = (state == StHash);
  assign cmp_way   = WW'(way - 1'b1);

  // Hash of the latched key feeds the modulo when it is started
  ikht_mod #(.BW(BW)) u_mod (
    .clk       (clk),
    .rst       (rst),
    .go        (mod_go),
    .dividend  (ikht_pkg::mix_key(key_r)),
    .divisor   (nbuck),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // Insert writes on final step: overwrite at hit way, else fill free way
  assign wr_en     = (state == StDone) && (cmd_r == ikht_pkg::CmdInsert) && (hit || has_free);
  assign wr_key_en = !hit;
  assign wr_way    = hit ? hit_way : free_way;

  ikht_store #(.AW(AW)) u_store (
    .clk       (clk),
    .rst       (rst),
    .rd_addr   ({bucket, way[WW-1:0]}),
    .rd_valid  (rd_valid),
    .rd_key    (rd_key),
    .rd_value  (rd_value),
    .wr_en     (wr_en),
    .wr_key_en (wr_key_en),
    .wr_addr   ({bucket, wr_way}),
    .wr_key    (key_r),
    .wr_value  (val_r),
    .clr_busy  (clr_busy)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) bucket_count <= ikht_pkg::BucketCountReset;
    else if (cfg_valid && cfg_ready) bucket_count <= cfg_data;
  end

  // Sequencer: hash, modulo, read each way, compare, respond
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        StIdle: begin
          if (start && !busy) state <= StHash;
        end
        StHash: state <= StMod;
        StMod: begin
          if (mod_done) state <= StRead;
        end
        StRead: state <= StCmp;
        StCmp: begin
          if (way == WCW'(WAYS)) state <= StDone;
        end
        StDone: begin
          state <= StIdle;
          done  <= 1'b1;
        end
        default: state <= StIdle;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      StIdle: begin
        cmd_r <= command;
        key_r <= key;
        val_r <= value;
      end
      StMod: begin
        bucket   <= mod_rem;
        way      <= '0;
        hit      <= 1'b0;
        has_free <= 1'b0;
        hit_way  <= '0;
        free_way <= '0;
      end
      StRead: way <= way + 1'b1;
      StCmp: begin
        // data for way-1 is valid now
        if (rd_valid) begin
          if (!hit && rd_key == key_r) begin
            hit       <= 1'b1;
            hit_way   <= cmp_way;
            hit_value <= rd_value;
          end
        end else if (!has_free) begin
          has_free <= 1'b1;
          free_way <= cmp_way;
        end
        if (way != WCW'(WAYS)) way <= way + 1'b1;
      end
      StDone: begin
        found      <= hit;
        read_value <= (cmd_r == ikht_pkg::CmdLookup && hit) ? hit_value : '0;
        status     <= (cmd_r == ikht_pkg::CmdInsert) && !hit && !has_free;
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  // A result follows only the final step
  a_done_after_final: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == StDone) else $error("done without final step");
  // No write while the table is still being cleared
  a_no_wr_clear: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !wr_en) else $error("write during clear");
  // Lookups never report a drop
  a_lookup_status: assert property (@(posedge clk) disable iff (rst)
    (done && cmd_r == ikht_pkg::CmdLookup) |-> !status) else $error("lookup dropped");
  // Busy holds while a command is in flight
  a_busy_run: assert property (@(posedge clk) disable iff (rst)
    (state != StIdle) |-> busy) else $error("not busy while running");
`endif

endmodule

@@ test/integer_key_hash_table_checker.sv @@
// Checker for the integer key hash table: watches the command, config and result
// channels, keeps its own copy of the table and compares every result word.
// Depends on ikht_pkg.
module integer_key_hash_table_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        command,
  input  logic [63:0] key,
  input  logic [63:0] value,
  input  logic        done,
  input  logic        found,
  input  logic [63:0] read_value,
  input  logic        status,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [10:0] cfg_data,
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumBuckets = ikht_pkg::DefMaxBuckets;
  localparam int NumWays    = ikht_pkg::DefWays;
  localparam int NumSlots   = NumBuckets * NumWays;

  typedef struct packed {
    logic        found;
    logic [63:0] read_value;
    logic        status;
  } reply_t;

  logic        slot_used [NumSlots];
  logic [63:0] slot_key  [NumSlots];
  logic [63:0] slot_val  [NumSlots];
  logic [10:0] buckets_cfg;
  reply_t      expected_replies[$];

  // 64-bit shift-add-xor mix, low 32 bits kept
  function automatic logic [31:0] key_mix(input logic [63:0] k);
    logic [63:0] h;
    h = k;
    h += ~(h << 15);
    h ^= h >> 10;
    h += h << 3;
    h ^= h >> 6;
    h += ~(h << 11);
    h ^= h >> 16;
    return h[31:0];
  endfunction

  // Apply one command to the table copy and return its reply word
  function automatic reply_t table_access(input logic cmd, input logic [63:0] k,
                                          input logic [63:0] v);
    int     n;
    int     base;
    int     hit;
    int     free_slot;
    reply_t r;
    n = (buckets_cfg == 0) ? 1 : (buckets_cfg > NumBuckets) ? NumBuckets : buckets_cfg;
    base = int'(key_mix(k) % n) * NumWays;
    hit = -1;
    free_slot = -1;
    r = '0;
    for (int w = 0; w < NumWays; w++) begin
      if (slot_used[base + w]) begin
        if (hit < 0 && slot_key[base + w] == k) hit = base + w;
      end else if (free_slot < 0) begin
        free_slot = base + w;
      end
    end
    if (cmd == ikht_pkg::CmdLookup) begin
      if (hit >= 0) begin
        r.found = 1'b1;
        r.read_value = slot_val[hit];
      end
    end else if (hit >= 0) begin
      slot_val[hit] = v;
      r.found = 1'b1;
    end else if (free_slot >= 0) begin
      slot_used[free_slot] = 1'b1;
      slot_key[free_slot] = k;
      slot_val[free_slot] = v;
    end else begin
      r.status = 1'b1;
    end
    return r;
  endfunction

  // Predict on accepted commands, compare on result strobes
  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      buckets_cfg = ikht_pkg::BucketCountReset;
      for (int i = 0; i < NumSlots; i++) slot_used[i] = 1'b0;
      expected_replies.delete();
    end else begin
      if (done) begin
        if (expected_replies.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result word with none expected: found=%0b value=%h status=%0b",
                     $realtime, found, read_value, status);
        end else begin
          want = expected_replies.pop_front();
          if (want.found !== found || want.read_value !== read_value ||
              want.status !== status) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: expected f=%0b v=%h s=%0b, got f=%0b v=%h s=%0b",
                       $realtime, want.found, want.read_value, want.status,
                       found, read_value, status);
          end
        end
      end
      if (cfg_valid && cfg_ready) buckets_cfg = cfg_data;
      if (start && !busy) expected_replies.push_back(table_access(command, key, value));
    end
    pending_count = expected_replies.size();
  end

  initial begin
    fail_count = 0;
    pending_count = 0;
  end

endmodule

@@ test/integer_key_hash_table_tb.sv @@
// Testbench top for the integer key hash table: reset, directed and random
// insert/lookup words across several bucket counts, and the verdict.
// Depends on ikht_pkg, integer_key_hash_table and integer_key_hash_table_checker.
module integer_key_hash_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        command;
  logic [63:0] key;
  logic [63:0] value;
  logic        done;
  logic        found;
  logic [63:0] read_value;
  logic        status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [10:0] cfg_data;
  int          fail_count;
  int          pending_count;
  int          sent_words;
  int          done_words;
  int          idle_pct;
  logic [63:0] key_pool[24];

  integer_key_hash_table u_top (.*);

  integer_key_hash_table_checker u_checker (.*);

  // Clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) if (!rst && done) done_words++;

  // Run limit
  initial begin
    #10ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // Send one command word; start stays high afterwards unless a gap follows
  task automatic send_word(input logic cmd, input logic [63:0] k, input logic [63:0] v);
    int gap;
    start <= 1'b1;
    command <= cmd;
    key <= k;
    value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_words++;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      command <= 1'($urandom);
      key <= {$urandom, $urandom};
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait for all results, let the block settle, then write the bucket count
  task automatic set_buckets(input logic [10:0] n);
    start <= 1'b0;
    @(posedge clk);
    while (done_words != sent_words) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= n;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] pick_value();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    logic [10:0] plan[10];
    logic [63:0] k;
    int          i;
    plan = '{11'd1024, 11'd1, 11'd3, 11'd2047, 11'd0, 11'd5, 11'd1024, 11'd2, 11'd17,
             11'd1024};
    rst = 1'b1;
    start = 1'b0;
    command = ikht_pkg::CmdInsert;
    key = '0;
    value = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    sent_words = 0;
    done_words = 0;
    idle_pct = 0;
    for (i = 0; i < 24; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes at the reset bucket count
    send_word(ikht_pkg::CmdLookup, '0, '1);
    send_word(ikht_pkg::CmdInsert, '0, '1);
    send_word(ikht_pkg::CmdInsert, '1, '0);
    send_word(ikht_pkg::CmdLookup, '0, '0);
    send_word(ikht_pkg::CmdLookup, '1, '1);
    send_word(ikht_pkg::CmdInsert, '0, 64'h0123_4567_89ab_cdef);
    send_word(ikht_pkg::CmdLookup, '0, '0);
    send_word(ikht_pkg::CmdLookup, 64'h8000_0000_0000_0001, '0);

    // Directed: one bucket, fill it, drop, overwrite while full
    set_buckets(11'd1);
    for (i = 2; i < 7; i++) send_word(ikht_pkg::CmdInsert, key_pool[i], {$urandom, $urandom});
    send_word(ikht_pkg::CmdLookup, key_pool[3], '0);
    send_word(ikht_pkg::CmdLookup, key_pool[6], '0);
    send_word(ikht_pkg::CmdInsert, key_pool[0], '1);
    send_word(ikht_pkg::CmdLookup, key_pool[0], '0);

    // Random: phases over bucket counts and idle patterns
    i = 0;
    for (int p = 0; p < 10; p++) begin
      set_buckets(plan[p]);
      for (int j = 0; j < 95; j++) begin
        idle_pct = (i < 317) ? 19 : (i < 634) ? 84 : 0;
        k = ($urandom_range(9) < 7) ? key_pool[$urandom_range(23)] : {$urandom, $urandom};
        send_word($urandom_range(1) ? ikht_pkg::CmdLookup : ikht_pkg::CmdInsert, k,
                  pick_value());
        i++;
      end
    end

    // Drain
    start <= 1'b0;
    @(posedge clk);
    while (done_words != sent_words) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ integer_key_hash_table.f @@
design/ikht_pkg.sv
design/ikht_mod.sv
design/ikht_store.sv
design/integer_key_hash_table.sv
test/integer_key_hash_table_checker.sv
test/integer_key_hash_table_tb.sv
